FILE: rtl/core/adsr_pkg.sv
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared widths, codes, control word layout and microcode for the envelope
// level block.
// ----------------------------------------------------------------------------
package adsr_pkg;

	// time and field widths
	localparam int TIME_BITS = 32;
	localparam int AT_TIME_W = 32;
	localparam int CMD_W     = 2;
	localparam int TICK_W    = 24;
	localparam int LEVEL_W   = 17;
	localparam int FRAC_W    = 16;
	localparam int CFG_W     = TICK_W;
	localparam int IDX_W     = 2;

	// divider: numerator is a tick count scaled by up to one, quotient up to one
	localparam int NUM_W     = TICK_W + FRAC_W;
	localparam int QUO_W     = LEVEL_W;
	localparam int REM_W     = TICK_W;
	localparam int DIV_STEPS = QUO_W;
	localparam int CNT_W     = $clog2(DIV_STEPS + 1);
	localparam int PROD_W    = 2 * LEVEL_W;
	localparam int DMUL_W    = TICK_W + LEVEL_W;
	localparam int CMP_W     = (TIME_BITS > TICK_W) ? TIME_BITS : TICK_W;

	localparam logic [LEVEL_W-1:0] UNITY = LEVEL_W'(1) << FRAC_W;

	// register reset values
	localparam logic [TICK_W-1:0]  ATTACK_RST  = TICK_W'(480);
	localparam logic [TICK_W-1:0]  DECAY_RST   = TICK_W'(4800);
	localparam logic [LEVEL_W-1:0] SUSTAIN_RST = LEVEL_W'(45875);
	localparam logic [TICK_W-1:0]  RELEASE_RST = TICK_W'(9600);

	typedef enum logic [CMD_W-1:0] {
		CMD_EVAL     = 2'd0,
		CMD_NOTE_ON  = 2'd1,
		CMD_NOTE_OFF = 2'd2
	} cmd_t;

	typedef enum logic [IDX_W-1:0] {
		REG_ATTACK  = 2'd0,
		REG_DECAY   = 2'd1,
		REG_SUSTAIN = 2'd2,
		REG_RELEASE = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [TICK_W-1:0]  attack_ticks;
		logic [TICK_W-1:0]  decay_ticks;
		logic [LEVEL_W-1:0] sustain_level;
		logic [TICK_W-1:0]  release_ticks;
	} cfg_t;

	// datapath operations
	typedef enum logic [3:0] {
		OP_HOLD,
		OP_IDLE,
		OP_ELAPSED,
		OP_ATK_LOAD,
		OP_DIV_START,
		OP_DIV_STEP,
		OP_ADS_ATK,
		OP_DEC_SUB,
		OP_DEC_MUL,
		OP_ADS_DEC,
		OP_ADS_SUS,
		OP_REL_PREP,
		OP_REL_DIV,
		OP_MUL,
		OP_EMIT
	} uop_t;

	// jump conditions
	typedef enum logic [2:0] {
		C_NEXT,
		C_ALWAYS,
		C_NOT_EVAL,
		C_X_GE_A,
		C_X_GE_D,
		C_DIV_BUSY,
		C_NO_RAMP,
		C_OUT_FULL
	} cond_t;

	localparam int PC_W = 5;
	typedef logic [PC_W-1:0] pc_t;

	// jump targets
	localparam pc_t PC_IDLE    = pc_t'(0);
	localparam pc_t PC_ATK_DIV = pc_t'(4);
	localparam pc_t PC_DECAY   = pc_t'(6);
	localparam pc_t PC_DEC_DIV = pc_t'(9);
	localparam pc_t PC_SUSTAIN = pc_t'(11);
	localparam pc_t PC_RELEASE = pc_t'(12);
	localparam pc_t PC_REL_DIV = pc_t'(14);
	localparam pc_t PC_PRODUCT = pc_t'(16);
	localparam pc_t PC_WAIT    = pc_t'(17);

	typedef struct packed {
		uop_t  op;
		cond_t cond;
		pc_t   target;
	} ctrl_t;

	typedef struct packed {
		logic x_ge_a;
		logic x_ge_d;
		logic div_busy;
		logic no_ramp;
	} status_t;

	function automatic ctrl_t uw(input uop_t op, input cond_t cond, input pc_t target);
		ctrl_t w;
		w.op     = op;
		w.cond   = cond;
		w.target = target;
		return w;
	endfunction

	// control store
	function automatic ctrl_t ucode(input pc_t pc);
		ctrl_t w;
		case (pc)
			5'd0:    w = uw(OP_IDLE,      C_NOT_EVAL, PC_IDLE);
			5'd1:    w = uw(OP_ELAPSED,   C_NEXT,     PC_IDLE);
			5'd2:    w = uw(OP_ATK_LOAD,  C_X_GE_A,   PC_DECAY);
			5'd3:    w = uw(OP_DIV_START, C_NEXT,     PC_IDLE);
			5'd4:    w = uw(OP_DIV_STEP,  C_DIV_BUSY, PC_ATK_DIV);
			5'd5:    w = uw(OP_ADS_ATK,   C_ALWAYS,   PC_RELEASE);
			5'd6:    w = uw(OP_DEC_SUB,   C_NEXT,     PC_IDLE);
			5'd7:    w = uw(OP_DEC_MUL,   C_X_GE_D,   PC_SUSTAIN);
			5'd8:    w = uw(OP_DIV_START, C_NEXT,     PC_IDLE);
			5'd9:    w = uw(OP_DIV_STEP,  C_DIV_BUSY, PC_DEC_DIV);
			5'd10:   w = uw(OP_ADS_DEC,   C_ALWAYS,   PC_RELEASE);
			5'd11:   w = uw(OP_ADS_SUS,   C_NEXT,     PC_IDLE);
			5'd12:   w = uw(OP_REL_PREP,  C_NO_RAMP,  PC_PRODUCT);
			5'd13:   w = uw(OP_DIV_START, C_NEXT,     PC_IDLE);
			5'd14:   w = uw(OP_DIV_STEP,  C_DIV_BUSY, PC_REL_DIV);
			5'd15:   w = uw(OP_REL_DIV,   C_NEXT,     PC_IDLE);
			5'd16:   w = uw(OP_MUL,       C_NEXT,     PC_IDLE);
			5'd17:   w = uw(OP_HOLD,      C_OUT_FULL, PC_WAIT);
			5'd18:   w = uw(OP_EMIT,      C_ALWAYS,   PC_IDLE);
			default: w = uw(OP_HOLD,      C_ALWAYS,   PC_IDLE);
		endcase
		return w;
	endfunction

endpackage

FILE: rtl/core/adsr_datapath.sv
// ----------------------------------------------------------------------------
// adsr_datapath
// Note time store, elapsed time, shared restoring divider, decay multiplier
// and final gain product, all driven by the sequencer's control word.
// ----------------------------------------------------------------------------
module adsr_datapath
	import adsr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctrl_t                ctrl,
	input  logic                 accept,
	input  logic [CMD_W-1:0]     command,
	input  logic [AT_TIME_W-1:0] at_time,
	input  cfg_t                 cfg,
	output status_t              status,
	output logic [LEVEL_W-1:0]   gain
);

	logic [TIME_BITS-1:0] on_tick_q;
	logic [TIME_BITS-1:0] off_tick_q;
	logic [TIME_BITS-1:0] t_q;
	logic [TIME_BITS-1:0] x_q;
	logic [NUM_W-1:0]     num_q;
	logic [TICK_W-1:0]    den_q;
	logic [REM_W-1:0]     rem_q;
	logic [QUO_W-1:0]     quo_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [LEVEL_W-1:0]   ads_q;
	logic [LEVEL_W-1:0]   rel_q;
	logic [PROD_W-1:0]    prod_q;

	logic [TIME_BITS-1:0] t_in;
	logic [TIME_BITS-1:0] elapsed;
	logic [TIME_BITS-1:0] rel_diff;
	logic [LEVEL_W-1:0]   sus_sat;
	logic [LEVEL_W-1:0]   rel_flat;
	logic                 ramp;
	logic [DMUL_W-1:0]    dec_prod;
	logic [REM_W:0]       trial;
	logic [REM_W:0]       trial_sub;
	logic                 trial_ge;
	logic [PROD_W-FRAC_W-1:0] prod_hi;

	assign t_in     = TIME_BITS'(at_time);
	assign sus_sat  = (cfg.sustain_level > UNITY) ? UNITY : cfg.sustain_level;
	assign elapsed  = (t_q < on_tick_q) ? '0 : t_q - on_tick_q;
	assign rel_diff = t_q - off_tick_q;

	// release ramp only after a later note-off and within the release time
	assign ramp = (on_tick_q < off_tick_q) && (t_q >= off_tick_q)
		&& (CMP_W'(rel_diff) < CMP_W'(cfg.release_ticks));
	// held note, or still before a later note-off; equal times give zero
	assign rel_flat = ((on_tick_q > off_tick_q)
		|| ((on_tick_q < off_tick_q) && (t_q < off_tick_q))) ? UNITY : '0;

	assign dec_prod = DMUL_W'(TICK_W'(x_q)) * DMUL_W'(UNITY - sus_sat);

	// one restoring step per cycle
	assign trial     = {rem_q, quo_q[QUO_W-1]};
	assign trial_ge  = trial >= {1'b0, den_q};
	assign trial_sub = trial - {1'b0, den_q};

	assign status.x_ge_a   = CMP_W'(x_q) >= CMP_W'(cfg.attack_ticks);
	assign status.x_ge_d   = CMP_W'(x_q) >= CMP_W'(cfg.decay_ticks);
	assign status.div_busy = cnt_q != CNT_W'(1);
	assign status.no_ramp  = !ramp;

	assign prod_hi = prod_q[PROD_W-1:FRAC_W];
	assign gain    = (prod_hi > (PROD_W-FRAC_W)'(UNITY)) ? UNITY : LEVEL_W'(prod_hi);

	// note times and divider count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_tick_q  <= '0;
			off_tick_q <= '0;
			cnt_q      <= '0;
		end else begin
			if (ctrl.op == OP_IDLE && accept) begin
				case (command)
					CMD_NOTE_ON:  on_tick_q  <= t_in;
					CMD_NOTE_OFF: off_tick_q <= t_in;
					default:      ;
				endcase
			end
			if (ctrl.op == OP_DIV_START) begin
				cnt_q <= CNT_W'(DIV_STEPS);
			end else if (ctrl.op == OP_DIV_STEP) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_IDLE: begin
				if (accept) begin
					t_q <= t_in;
				end
			end
			OP_ELAPSED: x_q <= elapsed;
			OP_ATK_LOAD: begin
				num_q <= NUM_W'({x_q, FRAC_W'(0)});
				den_q <= cfg.attack_ticks;
			end
			OP_DIV_START: begin
				rem_q <= REM_W'(num_q >> QUO_W);
				quo_q <= num_q[QUO_W-1:0];
			end
			OP_DIV_STEP: begin
				rem_q <= trial_ge ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], trial_ge};
			end
			OP_ADS_ATK: ads_q <= quo_q;
			OP_DEC_SUB: x_q <= x_q - TIME_BITS'(cfg.attack_ticks);
			OP_DEC_MUL: begin
				num_q <= NUM_W'(dec_prod);
				den_q <= cfg.decay_ticks;
			end
			OP_ADS_DEC: ads_q <= UNITY - quo_q;
			OP_ADS_SUS: ads_q <= sus_sat;
			OP_REL_PREP: begin
				rel_q <= rel_flat;
				num_q <= NUM_W'({rel_diff, FRAC_W'(0)});
				den_q <= cfg.release_ticks;
			end
			OP_REL_DIV: rel_q <= UNITY - quo_q;
			OP_MUL: prod_q <= PROD_W'(ads_q) * PROD_W'(rel_q);
			default: ;
		endcase
	end

endmodule

FILE: rtl/core/adsr_envelope_level.sv
// ----------------------------------------------------------------------------
// adsr_envelope_level
// ADSR envelope gain in unsigned Q1.16: records note-on and note-off times
// and evaluates the attack/decay/sustain shape times the release shape.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                    payload
//  item      in         item_valid / item_ready      command, at_time
//  result    out        result_valid / result_ready  gain
//  config    in         cfg_write (no wait)          cfg_index, cfg_data
//
//  a note-on or note-off beat is taken on the idle step and stays there; an evaluate
//  beat runs through the serial divider (17 steps per division, up to two per beat)
//  reset clears the note times to zero and loads the register defaults
//  item_ready is high only on the sequencer's idle step; a held result stalls
//  the sequencer on its wait step until the output register is free
//
module adsr_envelope_level
	import adsr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  logic [CMD_W-1:0]     command,
	input  logic [AT_TIME_W-1:0] at_time,
	output logic                 result_valid,
	input  logic                 result_ready,
	output logic [LEVEL_W-1:0]   gain,
	input  logic                 cfg_write,
	input  logic [IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	// sequencer state
	pc_t     pc_q;
	pc_t     pc_next;
	ctrl_t   ctrl;
	logic    take_jump;
	logic    accept;
	status_t status;

	// configuration registers
	cfg_t cfg_q;

	// output register
	logic               result_valid_q;
	logic [LEVEL_W-1:0] gain_q;
	logic [LEVEL_W-1:0] dp_gain;
	logic               out_full;

	// control word for the current step
	assign ctrl     = ucode(pc_q);
	assign accept   = item_valid && item_ready;
	assign out_full = result_valid_q && !result_ready;

	// next step: conditional jump or fall through
	always_comb begin
		case (ctrl.cond)
			C_NEXT:     take_jump = 1'b0;
			C_ALWAYS:   take_jump = 1'b1;
			C_NOT_EVAL: take_jump = !(accept && command == CMD_EVAL);
			C_X_GE_A:   take_jump = status.x_ge_a;
			C_X_GE_D:   take_jump = status.x_ge_d;
			C_DIV_BUSY: take_jump = status.div_busy;
			C_NO_RAMP:  take_jump = status.no_ramp;
			C_OUT_FULL: take_jump = out_full;
			default:    take_jump = 1'b1;
		endcase
		pc_next = take_jump ? ctrl.target : pc_q + pc_t'(1);
	end

	// handshake outputs
	always_comb begin
		item_ready   = ctrl.op == OP_IDLE;
		result_valid = result_valid_q;
		gain         = gain_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

	// register writes, unknown index leaves everything alone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attack_ticks  <= ATTACK_RST;
			cfg_q.decay_ticks   <= DECAY_RST;
			cfg_q.sustain_level <= SUSTAIN_RST;
			cfg_q.release_ticks <= RELEASE_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ATTACK:  cfg_q.attack_ticks  <= cfg_data[TICK_W-1:0];
				REG_DECAY:   cfg_q.decay_ticks   <= cfg_data[TICK_W-1:0];
				REG_SUSTAIN: cfg_q.sustain_level <= cfg_data[LEVEL_W-1:0];
				REG_RELEASE: cfg_q.release_ticks <= cfg_data[TICK_W-1:0];
				default:     ;
			endcase
		end
	end

	// result beat holds until taken; the emit step only runs when it is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (ctrl.op == OP_EMIT) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == OP_EMIT) begin
			gain_q <= dp_gain;
		end
	end

	adsr_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.accept  (accept),
		.command (command),
		.at_time (at_time),
		.cfg     (cfg_q),
		.status  (status),
		.gain    (dp_gain)
	);

`ifndef SYNTHESIS
	// never overwrite a beat that is still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_EMIT) |-> !result_valid_q)
		else $error("emit step with output register still full");

	// gain stays within zero to one
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (gain <= UNITY))
		else $error("gain above full scale");

	// a note event leaves the sequencer on its idle step
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && command != CMD_EVAL) |=> item_ready)
		else $error("sequencer left idle on a note event");
`endif

endmodule

FILE: verif/adsr_envelope_level_checker.sv
// ----------------------------------------------------------------------------
// adsr_envelope_level_checker
// Watches the item, result and register write ports of the envelope level
// block, keeps its own note times and register copies, predicts the gain of
// every evaluate beat and compares it with the gain beats in order.
// ----------------------------------------------------------------------------
module adsr_envelope_level_checker
	import adsr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  logic                 item_ready,
	input  logic [CMD_W-1:0]     command,
	input  logic [AT_TIME_W-1:0] at_time,
	input  logic                 result_valid,
	input  logic                 result_ready,
	input  logic [LEVEL_W-1:0]   gain,
	input  logic                 cfg_write,
	input  logic [IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   mismatches,
	output int                   gains_owed,
	output int                   gains_checked
);

	localparam longint unsigned FULL_SCALE = 64'd65536;
	localparam longint unsigned TICK_MASK  = (64'd1 << TIME_BITS) - 64'd1;

	longint unsigned    attack_len;
	longint unsigned    decay_len;
	longint unsigned    sustain_raw;
	longint unsigned    release_len;
	longint unsigned    on_tick;
	longint unsigned    off_tick;
	longint unsigned    stamp;
	logic [LEVEL_W-1:0] gain_due[$];
	logic [LEVEL_W-1:0] want;

	// attack/decay/sustain shape times the release shape, floored at each step
	function automatic logic [LEVEL_W-1:0] predict_gain(input longint unsigned t);
		longint unsigned lvl;
		longint unsigned elapsed;
		longint unsigned past;
		longint unsigned shape;
		longint unsigned fade;
		longint unsigned since;
		longint unsigned g;
		lvl     = (sustain_raw > FULL_SCALE) ? FULL_SCALE : sustain_raw;
		elapsed = (t < on_tick) ? 64'd0 : t - on_tick;
		if (elapsed < attack_len) begin
			shape = (elapsed * FULL_SCALE) / attack_len;
		end else begin
			past = elapsed - attack_len;
			if (past < decay_len)
				shape = FULL_SCALE - (past * (FULL_SCALE - lvl)) / decay_len;
			else
				shape = lvl;
		end
		if (on_tick > off_tick) begin
			fade = FULL_SCALE;
		end else if (on_tick == off_tick) begin
			fade = 64'd0;
		end else if (t < off_tick) begin
			fade = FULL_SCALE;
		end else begin
			since = t - off_tick;
			fade  = (since >= release_len) ? 64'd0
			      : FULL_SCALE - (since * FULL_SCALE) / release_len;
		end
		g = (shape * fade) >> 16;
		if (g > FULL_SCALE)
			g = FULL_SCALE;
		return g[LEVEL_W-1:0];
	endfunction

	task automatic log_fault(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] checker: %s", $time, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_len    = ATTACK_RST;
			decay_len     = DECAY_RST;
			sustain_raw   = SUSTAIN_RST;
			release_len   = RELEASE_RST;
			on_tick       = 64'd0;
			off_tick      = 64'd0;
			gain_due.delete();
			gains_owed    = 0;
		end else begin
			// retire first: a gain beat never belongs to an item taken this edge
			if (result_valid && result_ready) begin
				if (gain_due.size() == 0) begin
					log_fault($sformatf("gain beat %0d with nothing pending", gain));
				end else begin
					want = gain_due.pop_front();
					gains_checked++;
					if (gain !== want)
						log_fault($sformatf("gain mismatch, expected %0d, got %0d",
							want, gain));
				end
			end
			if (item_valid && item_ready) begin
				stamp = at_time & TICK_MASK;
				case (command)
					CMD_EVAL:     gain_due = {gain_due, predict_gain(stamp)};
					CMD_NOTE_ON:  on_tick = stamp;
					CMD_NOTE_OFF: off_tick = stamp;
					default:      ;
				endcase
			end
			if (cfg_write) begin
				case (cfg_index)
					REG_ATTACK:  attack_len  = cfg_data[TICK_W-1:0];
					REG_DECAY:   decay_len   = cfg_data[TICK_W-1:0];
					REG_SUSTAIN: sustain_raw = cfg_data[LEVEL_W-1:0];
					REG_RELEASE: release_len = cfg_data[TICK_W-1:0];
					default:     ;
				endcase
			end
			gains_owed = gain_due.size();
		end
	end

endmodule

FILE: verif/adsr_envelope_level_tb.sv
// ----------------------------------------------------------------------------
// adsr_envelope_level_tb
// Drives note-on, note-off and evaluate beats into the envelope level block
// under several register settings, with random gaps on the item side and
// random stalls on the gain side; the checker beside the block predicts and
// compares every gain, and this top gives the verdict.
// ----------------------------------------------------------------------------
module adsr_envelope_level_tb;
	import adsr_pkg::*;

	// command code the block has no use for, it must be dropped silently
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	// cycles to let a note beat or a last evaluate drain before a register write
	localparam int DRAIN_CYCLES = 64;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 item_valid   = 1'b0;
	logic                 item_ready;
	logic [CMD_W-1:0]     command      = '0;
	logic [AT_TIME_W-1:0] at_time      = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	logic [LEVEL_W-1:0]   gain;
	logic                 cfg_write    = 1'b0;
	logic [IDX_W-1:0]     cfg_index    = '0;
	logic [CFG_W-1:0]     cfg_data     = '0;

	int mismatches;
	int gains_owed;
	int gains_checked;

	// stimulus bookkeeping
	logic                 quiet      = 1'b0;
	int                   stall_left = 0;
	int                   evals_sent = 0;
	int                   ons_sent   = 0;
	int                   offs_sent  = 0;
	int                   drops_sent = 0;
	int                   settings   = 1;
	int                   phase;
	logic [AT_TIME_W-1:0] atk_span;
	logic [AT_TIME_W-1:0] dec_span;
	logic [AT_TIME_W-1:0] rel_span;

	adsr_envelope_level u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.command      (command),
		.at_time      (at_time),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.gain         (gain),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	adsr_envelope_level_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.command       (command),
		.at_time       (at_time),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.gain          (gain),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.gains_owed    (gains_owed),
		.gains_checked (gains_checked)
	);

	// 8 unit period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// idle length for either side: mostly none or short, now and then long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet)
			return 0;
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// gain side: ready drops for random stretches, independent of valid
	always @(negedge clk) begin
		if (stall_left != 0) begin
			result_ready <= 1'b0;
			stall_left   <= stall_left - 1;
		end else begin
			result_ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				stall_left <= pick_gap();
		end
	end

	// one item beat: optional gap, then valid held with a steady payload until taken
	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [AT_TIME_W-1:0] t);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		command    <= cmd;
		at_time    <= t;
		do @(posedge clk); while (!item_ready);
		case (cmd)
			CMD_EVAL:     evals_sent++;
			CMD_NOTE_ON:  ons_sent++;
			CMD_NOTE_OFF: offs_sent++;
			default:      drops_sent++;
		endcase
	endtask

	// stop sending, wait for every pending gain, then let a note beat finish too
	task automatic settle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (gains_owed != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// writes all four registers on back-to-back cycles, block idle
	task automatic load_config(input logic [CFG_W-1:0] atk, input logic [CFG_W-1:0] dec,
		input logic [CFG_W-1:0] sus, input logic [CFG_W-1:0] rel);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= REG_ATTACK;
		cfg_data  <= atk;
		@(negedge clk);
		cfg_index <= REG_DECAY;
		cfg_data  <= dec;
		@(negedge clk);
		cfg_index <= REG_SUSTAIN;
		cfg_data  <= sus;
		@(negedge clk);
		cfg_index <= REG_RELEASE;
		cfg_data  <= rel;
		@(negedge clk);
		cfg_write <= 1'b0;
		atk_span = AT_TIME_W'(atk[TICK_W-1:0]);
		dec_span = AT_TIME_W'(dec[TICK_W-1:0]);
		rel_span = AT_TIME_W'(rel[TICK_W-1:0]);
		settings++;
	endtask

	// phase length: zero, one, full width, or a short musical value
	function automatic logic [CFG_W-1:0] pick_ticks();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return CFG_W'(1);
			2:       return '1;
			default: return CFG_W'($urandom_range(1, 5000));
		endcase
	endfunction

	// sustain: the ends, just under full scale, or raw bits that may be oversized
	function automatic logic [CFG_W-1:0] pick_level();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return CFG_W'(UNITY);
			2:       return CFG_W'(UNITY) - CFG_W'(1);
			3:       return CFG_W'($urandom());
			default: return CFG_W'($urandom_range(0, 65536));
		endcase
	endfunction

	// offset that lands on a phase edge, one either side of it, or anywhere near
	function automatic logic [AT_TIME_W-1:0] near_edge(input logic [AT_TIME_W-1:0] len);
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return len;
			2:       return len - 1;
			3:       return len + 1;
			default: return $urandom_range(0, len + len / 4 + 2);
		endcase
	endfunction

	// mostly whole notes with evaluations through every phase, some noise beats
	task automatic play_notes(input int target);
		int                   goal;
		logic [AT_TIME_W-1:0] onset;
		logic [AT_TIME_W-1:0] cutoff;
		goal = evals_sent + ons_sent + offs_sent + target;
		while (evals_sent + ons_sent + offs_sent < goal) begin
			if ($urandom_range(0, 9) == 0) begin
				// noise: any command, unused one included, at any time
				send_item(CMD_W'($urandom_range(0, 3)), $urandom());
			end else begin
				case ($urandom_range(0, 7))
					0:       onset = $urandom_range(0, 4000);
					1:       onset = '1 - $urandom_range(0, 4000);
					default: onset = $urandom();
				endcase
				send_item(CMD_NOTE_ON, onset);
				// attack, decay and sustain region, edges favored
				repeat ($urandom_range(1, 4))
					send_item(CMD_EVAL, onset + near_edge($urandom_range(0, 1) ?
						atk_span : atk_span + dec_span));
				if ($urandom_range(0, 7) == 0)
					send_item(CMD_EVAL, onset - $urandom_range(1, 2000));
				// most notes get released, some are left held
				if ($urandom_range(0, 7) != 0) begin
					case ($urandom_range(0, 5))
						0:       cutoff = onset;
						1:       cutoff = onset - $urandom_range(1, 5000);
						default: cutoff = onset + near_edge(atk_span + dec_span);
					endcase
					send_item(CMD_NOTE_OFF, cutoff);
					repeat ($urandom_range(1, 4))
						send_item(CMD_EVAL, cutoff + near_edge(rel_span));
					if ($urandom_range(0, 5) == 0)
						send_item(CMD_EVAL, cutoff - $urandom_range(1, 3000));
				end
			end
		end
	endtask

	initial begin
		atk_span = AT_TIME_W'(ATTACK_RST);
		dec_span = AT_TIME_W'(DECAY_RST);
		rel_span = AT_TIME_W'(RELEASE_RST);
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: 480 attack, 4800 decay, 45875 sustain, 9600 release
		send_item(CMD_EVAL, 32'd0);             // both note times zero after reset
		send_item(CMD_UNUSED, 32'hFFFF_FFFF);   // dropped, no gain beat
		send_item(CMD_NOTE_ON, 32'd1000);
		send_item(CMD_EVAL, 32'd500);           // before note-on, clamps to zero
		send_item(CMD_EVAL, 32'd1240);          // mid attack
		send_item(CMD_EVAL, 32'd1480);          // top of attack
		send_item(CMD_EVAL, 32'd3880);          // mid decay
		send_item(CMD_EVAL, 32'd100000);        // sustain, note held
		send_item(CMD_NOTE_OFF, 32'd200000);
		send_item(CMD_EVAL, 32'd150000);        // before note-off, release part one
		send_item(CMD_EVAL, 32'd200000);        // release start
		send_item(CMD_EVAL, 32'd204800);        // mid release
		send_item(CMD_EVAL, 32'd209600);        // release done
		send_item(CMD_EVAL, 32'hFFFF_FFFF);     // latest time
		send_item(CMD_NOTE_ON, 32'hFFFF_FFFF);
		send_item(CMD_EVAL, 32'd0);             // far before note-on
		settle();

		// zero-length phases and an oversized sustain that saturates
		load_config('0, '0, CFG_W'(24'h01FFFF), '0);
		send_item(CMD_NOTE_ON, 32'd10);
		send_item(CMD_NOTE_OFF, 32'd10);
		send_item(CMD_EVAL, 32'd10);            // equal note times
		send_item(CMD_NOTE_OFF, 32'd20);
		send_item(CMD_EVAL, 32'd19);            // full gain just before note-off
		send_item(CMD_EVAL, 32'd20);            // zero release silences at once
		send_item(CMD_EVAL, 32'd15);
		send_item(CMD_EVAL, 32'd5);
		play_notes(40);
		settle();

		// widest phases, zero sustain
		load_config('1, '1, '0, '1);
		play_notes(60);

		// random settings, one phase with neither side idling
		for (phase = 0; phase < 5; phase++) begin
			settle();
			quiet = (phase == 2);
			load_config(pick_ticks(), pick_ticks(), pick_level(), pick_ticks());
			play_notes(85);
		end
		quiet = 1'b0;
		settle();

		$display("sent %0d evaluate, %0d note-on, %0d note-off and %0d unused beats",
			evals_sent, ons_sent, offs_sent, drops_sent);
		$display("under %0d register settings; %0d gains compared, %0d mismatches",
			settings, gains_checked, mismatches);
		if (mismatches == 0 && gains_owed == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#4000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
